FILE: hdl/sbpb_pkg.sv
// ----------------------------------------------------------------------------
// Servo bus packet builder package
// Shared types and constants: command codes, lane kinds, scaling constants
// and the packet record that passes from the merge stage to the serializer.
// ----------------------------------------------------------------------------
package sbpb_pkg;

   typedef enum logic [2:0] {
      ACT_SERVO_WRITE  = 3'd0,
      ACT_WHEEL_MODE   = 3'd1,
      ACT_SYNC_WHEELS  = 3'd2,
      ACT_SYNC_SERVOS  = 3'd3,
      ACT_SYNC_LIMITED = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      LANE_ANGLE = 2'd0,
      LANE_PCT   = 2'd1,
      LANE_MOVE  = 2'd2,
      LANE_WHEEL = 2'd3
   } lane_kind_type;

   localparam logic [7:0] HDR_BYTE   = 8'hFF;
   localparam logic [7:0] BCAST_ID   = 8'hFE;
   localparam logic [7:0] INS_WRITE  = 8'h03;
   localparam logic [7:0] INS_SYNC   = 8'h83;
   localparam logic [7:0] ADDR_GOAL  = 8'h1E;
   localparam logic [7:0] ADDR_SPEED = 8'h20;
   localparam logic [7:0] ADDR_CCW   = 8'h08;

   localparam logic [7:0] LEN_SERVO  = 8'h07;
   localparam logic [7:0] LEN_WHEEL  = 8'h05;
   localparam logic [7:0] LEN_SWHEEL = 8'h0A;
   localparam logic [7:0] LEN_SYNC4  = 8'h0E;
   localparam logic [7:0] SYNC_LEN2  = 8'h02;
   localparam logic [7:0] SYNC_LEN4  = 8'h04;

   localparam logic [10:0] RAW_FULL  = 11'd1023;

   localparam logic signed [16:0] ANGLE_FULL = 17'sd30000;
   localparam logic signed [16:0] PCT_FULL   = 17'sd10000;

   localparam int SCALE_SHIFT = 40;
   localparam logic [26:0] RECIP_ANGLE =
      27'(((64'd1 << SCALE_SHIFT) + 64'd30000 - 64'd1) / 64'd30000);
   localparam logic [26:0] RECIP_PCT =
      27'(((64'd1 << SCALE_SHIFT) + 64'd10000 - 64'd1) / 64'd10000);

   localparam int PKT_MAX  = 18;
   localparam int BODY_MAX = 16;

   typedef struct packed {
      action_type  action;
      logic [7:0]  id_a;
      logic [7:0]  id_b;
      logic        wheel_enable;
   } cmd_type;

   typedef struct packed {
      logic [PKT_MAX-1:0][7:0] bytes;
      logic [4:0]              count;
   } packet_type;

endpackage

FILE: hdl/sbpb_scale_lane.sv
// ----------------------------------------------------------------------------
// Scaling lane
// Clamps one angle, speed or percent and scales it to the 10-bit servo range
// by an exact reciprocal multiply, with wheel direction and moving speed rules.
// ----------------------------------------------------------------------------
module sbpb_scale_lane
   import sbpb_pkg::*;
(
   input  logic                clock,
   input  logic                en1,
   input  logic                en2,
   input  lane_kind_type       kind,
   input  logic signed [15:0]  value,
   output logic        [10:0]  raw
);

   logic signed [16:0] xs;
   logic signed [16:0] mag;
   logic signed [16:0] limit;
   logic        [14:0] clamped;
   logic        [24:0] p_in;
   logic        [24:0] p_ff;
   lane_kind_type      kind1_ff;
   lane_kind_type      kind2_ff;
   logic               neg_in;
   logic               neg1_ff;
   logic               neg2_ff;
   logic               pos_in;
   logic               pos1_ff;
   logic               pos2_ff;
   logic        [26:0] recip;
   logic        [51:0] prod_in;
   logic        [51:0] prod_ff;
   logic        [9:0]  quot;

   always_comb begin
      xs     = {value[15], value};
      neg_in = (kind == LANE_WHEEL) && value[15];
      pos_in = (xs > 17'sd0);
      mag    = neg_in ? -xs : xs;
      limit  = (kind == LANE_ANGLE) ? ANGLE_FULL : PCT_FULL;
      if (mag < 17'sd0) begin
         clamped = '0;
      end else if (mag > limit) begin
         clamped = limit[14:0];
      end else begin
         clamped = mag[14:0];
      end
      p_in = {clamped, 10'd0} - {10'd0, clamped};
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         p_ff     <= p_in;
         kind1_ff <= kind;
         neg1_ff  <= neg_in;
         pos1_ff  <= pos_in;
      end
   end

   always_comb begin
      recip   = (kind1_ff == LANE_ANGLE) ? RECIP_ANGLE : RECIP_PCT;
      prod_in = 52'(p_ff) * 52'(recip);
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         prod_ff  <= prod_in;
         kind2_ff <= kind1_ff;
         neg2_ff  <= neg1_ff;
         pos2_ff  <= pos1_ff;
      end
   end

   always_comb begin
      quot = prod_ff[SCALE_SHIFT +: 10];
      case (kind2_ff)
         LANE_MOVE: begin
            raw = (quot == 10'd0 && pos2_ff) ? 11'd1 : {1'b0, quot};
         end
         LANE_WHEEL: begin
            raw = {neg2_ff, quot};
         end
         default: begin
            raw = {1'b0, quot};
         end
      endcase
   end

endmodule

FILE: hdl/sbpb_packet_merge.sv
// ----------------------------------------------------------------------------
// Packet merge stage
// Combines the lane results and the command fields into the framed packet,
// computes the inverted checksum and the byte count.
// ----------------------------------------------------------------------------
module sbpb_packet_merge
   import sbpb_pkg::*;
(
   input  cmd_type       cmd,
   input  logic [10:0]   angle_a_raw,
   input  logic [10:0]   angle_b_raw,
   input  logic [10:0]   wheel_a_raw,
   input  logic [10:0]   wheel_b_raw,
   input  logic [10:0]   pct_raw,
   output logic          pkt_ok,
   output packet_type    pkt
);

   logic [BODY_MAX-1:0][7:0] body;
   logic [7:0]  lvl1 [8];
   logic [7:0]  lvl2 [4];
   logic [7:0]  lvl3 [2];
   logic [7:0]  sum;
   logic [4:0]  len;
   logic [10:0] mode_limit;

   always_comb begin
      body       = '0;
      len        = 5'd1;
      pkt_ok     = 1'b1;
      mode_limit = cmd.wheel_enable ? 11'd0 : RAW_FULL;
      case (cmd.action)
         ACT_SERVO_WRITE: begin
            body[0] = cmd.id_a;
            body[1] = LEN_SERVO;
            body[2] = INS_WRITE;
            body[3] = ADDR_GOAL;
            body[4] = angle_a_raw[7:0];
            body[5] = {5'd0, angle_a_raw[10:8]};
            body[6] = pct_raw[7:0];
            body[7] = {5'd0, pct_raw[10:8]};
            len     = 5'd11;
         end
         ACT_WHEEL_MODE: begin
            body[0] = cmd.id_a;
            body[1] = LEN_WHEEL;
            body[2] = INS_WRITE;
            body[3] = ADDR_CCW;
            body[4] = mode_limit[7:0];
            body[5] = {5'd0, mode_limit[10:8]};
            len     = 5'd9;
         end
         ACT_SYNC_WHEELS: begin
            body[0]  = BCAST_ID;
            body[1]  = LEN_SWHEEL;
            body[2]  = INS_SYNC;
            body[3]  = ADDR_SPEED;
            body[4]  = SYNC_LEN2;
            body[5]  = cmd.id_a;
            body[6]  = wheel_a_raw[7:0];
            body[7]  = {5'd0, wheel_a_raw[10:8]};
            body[8]  = cmd.id_b;
            body[9]  = wheel_b_raw[7:0];
            body[10] = {5'd0, wheel_b_raw[10:8]};
            len      = 5'd14;
         end
         ACT_SYNC_SERVOS: begin
            body[0]  = BCAST_ID;
            body[1]  = LEN_SYNC4;
            body[2]  = INS_SYNC;
            body[3]  = ADDR_GOAL;
            body[4]  = SYNC_LEN4;
            body[5]  = cmd.id_a;
            body[6]  = angle_a_raw[7:0];
            body[7]  = {5'd0, angle_a_raw[10:8]};
            body[8]  = pct_raw[7:0];
            body[9]  = {5'd0, pct_raw[10:8]};
            body[10] = cmd.id_b;
            body[11] = angle_b_raw[7:0];
            body[12] = {5'd0, angle_b_raw[10:8]};
            body[13] = pct_raw[7:0];
            body[14] = {5'd0, pct_raw[10:8]};
            len      = 5'd18;
         end
         ACT_SYNC_LIMITED: begin
            body[0]  = BCAST_ID;
            body[1]  = LEN_SYNC4;
            body[2]  = INS_SYNC;
            body[3]  = ADDR_SPEED;
            body[4]  = SYNC_LEN4;
            body[5]  = cmd.id_a;
            body[6]  = wheel_a_raw[7:0];
            body[7]  = {5'd0, wheel_a_raw[10:8]};
            body[8]  = pct_raw[7:0];
            body[9]  = {5'd0, pct_raw[10:8]};
            body[10] = cmd.id_b;
            body[11] = wheel_b_raw[7:0];
            body[12] = {5'd0, wheel_b_raw[10:8]};
            body[13] = pct_raw[7:0];
            body[14] = {5'd0, pct_raw[10:8]};
            len      = 5'd18;
         end
         default: begin
            pkt_ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         lvl1[i] = body[2*i] + body[2*i+1];
      end
      for (int i = 0; i < 4; i++) begin
         lvl2[i] = lvl1[2*i] + lvl1[2*i+1];
      end
      for (int i = 0; i < 2; i++) begin
         lvl3[i] = lvl2[2*i] + lvl2[2*i+1];
      end
      sum = lvl3[0] + lvl3[1];
   end

   always_comb begin
      pkt.bytes    = '0;
      pkt.bytes[0] = HDR_BYTE;
      pkt.bytes[1] = HDR_BYTE;
      for (int i = 0; i < PKT_MAX - 2; i++) begin
         pkt.bytes[i+2] = body[i];
      end
      for (int i = 0; i < PKT_MAX; i++) begin
         if (5'(i) == len - 5'd1) begin
            pkt.bytes[i] = ~sum;
         end
      end
      pkt.count = len - 5'd1;
   end

endmodule

FILE: hdl/sbpb_serializer.sv
// ----------------------------------------------------------------------------
// Packet serializer
// Holds one framed packet in a shift register and sends it one byte per
// cycle, flagging the checksum byte.
// ----------------------------------------------------------------------------
module sbpb_serializer
   import sbpb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  packet_type  pkt,
   output logic        free,
   output logic        strobe,
   output logic [7:0]  data,
   output logic        last
);

   logic [PKT_MAX-1:0][7:0] buf_ff;
   logic [PKT_MAX-1:0][7:0] buf_in;
   logic [4:0]              cnt_ff;
   logic [4:0]              cnt_in;
   logic                    valid_ff;
   logic                    valid_in;
   logic                    done;

   assign done   = valid_ff && (cnt_ff == 5'd0);
   assign free   = !valid_ff || done;
   assign strobe = valid_ff;
   assign data   = buf_ff[0];
   assign last   = done;

   always_comb begin
      buf_in   = buf_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      if (load) begin
         buf_in   = pkt.bytes;
         cnt_in   = pkt.count;
         valid_in = 1'b1;
      end else if (done) begin
         valid_in = 1'b0;
      end else if (valid_ff) begin
         for (int i = 0; i < PKT_MAX - 1; i++) begin
            buf_in[i] = buf_ff[i+1];
         end
         buf_in[PKT_MAX-1] = '0;
         cnt_in = cnt_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("Packet loaded over a transaction in progress.");

   a_end_of_packet: assert property (@(posedge clock) disable iff (reset)
      (done && !load) |=> !valid_ff)
      else $error("Strobe continued after the last byte.");

   a_count_down: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !done) |=> (valid_ff && cnt_ff == $past(cnt_ff) - 5'd1))
      else $error("Byte count did not step down during a packet.");

endmodule

FILE: hdl/servo_bus_packet_builder_unit.sv
// ----------------------------------------------------------------------------
// Servo bus packet builder
// A command is taken at a rising edge with start high and busy low. Five
// scaling lanes clamp and scale the two angles, the two wheel speeds and the
// percent side by side in a two-stage pipeline (clamp and times 1023, then
// the reciprocal multiply). The merge stage frames the packet and computes
// the checksum, and the serializer sends it on rsp_packet_byte, one byte per
// cycle with rsp_strobe high and rsp_last_byte on the checksum byte.
// A taken command passes both lane stages and then loads the serializer once
// it is free. A packet is 9, 11, 14 or 18 bytes long; the serializer sets the
// throughput, and packets follow each other with no gap because the next
// command waits in the lane pipeline while the current packet goes out.
// Commands with an unused action code give no bytes at all; such a command
// waiting behind a packet leaves the bus side idle before the next packet.
// Reset clears the pipeline and the serializer; no packet is in flight after
// it. The receiver cannot stall: each byte is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module servo_bus_packet_builder_unit
   import sbpb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic        [2:0]   req_action,
   input  logic        [7:0]   req_id_a,
   input  logic        [7:0]   req_id_b,
   input  logic signed [15:0]  req_angle_a,
   input  logic signed [15:0]  req_angle_b,
   input  logic signed [14:0]  req_speed_a,
   input  logic signed [14:0]  req_speed_b,
   input  logic signed [14:0]  req_percent,
   input  logic                req_wheel_enable,
   output logic                rsp_strobe,
   output logic        [7:0]   rsp_packet_byte,
   output logic                rsp_last_byte
);

   logic          s1_valid_ff;
   logic          s1_valid_in;
   logic          s2_valid_ff;
   logic          s2_valid_in;
   logic          s1_ready;
   logic          s2_ready;
   logic          accept;
   logic          ser_free;
   logic          take;
   logic          load;
   cmd_type       cmd_req;
   cmd_type       s1_cmd_ff;
   cmd_type       s2_cmd_ff;
   lane_kind_type pct_kind;
   logic [10:0]   angle_a_raw;
   logic [10:0]   angle_b_raw;
   logic [10:0]   wheel_a_raw;
   logic [10:0]   wheel_b_raw;
   logic [10:0]   pct_raw;
   logic          pkt_ok;
   packet_type    pkt;

   assign s2_ready = !s2_valid_ff || ser_free;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign busy     = !s1_ready;
   assign accept   = start && s1_ready;
   assign take     = s2_valid_ff && ser_free;
   assign load     = take && pkt_ok;

   always_comb begin
      cmd_req.action       = action_type'(req_action);
      cmd_req.id_a         = req_id_a;
      cmd_req.id_b         = req_id_b;
      cmd_req.wheel_enable = req_wheel_enable;
      if (req_action inside {ACT_SERVO_WRITE, ACT_SYNC_SERVOS}) begin
         pct_kind = LANE_MOVE;
      end else begin
         pct_kind = LANE_PCT;
      end
   end

   always_comb begin
      s1_valid_in = s1_ready ? accept : s1_valid_ff;
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_cmd_ff <= cmd_req;
      end
      if (s2_ready) begin
         s2_cmd_ff <= s1_cmd_ff;
      end
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   sbpb_scale_lane u_lane_angle_a (
      .clock (clock),
      .en1   (s1_ready),
      .en2   (s2_ready),
      .kind  (LANE_ANGLE),
      .value (req_angle_a),
      .raw   (angle_a_raw)
   );

   sbpb_scale_lane u_lane_angle_b (
      .clock (clock),
      .en1   (s1_ready),
      .en2   (s2_ready),
      .kind  (LANE_ANGLE),
      .value (req_angle_b),
      .raw   (angle_b_raw)
   );

   sbpb_scale_lane u_lane_wheel_a (
      .clock (clock),
      .en1   (s1_ready),
      .en2   (s2_ready),
      .kind  (LANE_WHEEL),
      .value ({req_speed_a[14], req_speed_a}),
      .raw   (wheel_a_raw)
   );

   sbpb_scale_lane u_lane_wheel_b (
      .clock (clock),
      .en1   (s1_ready),
      .en2   (s2_ready),
      .kind  (LANE_WHEEL),
      .value ({req_speed_b[14], req_speed_b}),
      .raw   (wheel_b_raw)
   );

   sbpb_scale_lane u_lane_pct (
      .clock (clock),
      .en1   (s1_ready),
      .en2   (s2_ready),
      .kind  (pct_kind),
      .value ({req_percent[14], req_percent}),
      .raw   (pct_raw)
   );

   sbpb_packet_merge u_merge (
      .cmd         (s2_cmd_ff),
      .angle_a_raw (angle_a_raw),
      .angle_b_raw (angle_b_raw),
      .wheel_a_raw (wheel_a_raw),
      .wheel_b_raw (wheel_b_raw),
      .pct_raw     (pct_raw),
      .pkt_ok      (pkt_ok),
      .pkt         (pkt)
   );

   sbpb_serializer u_serializer (
      .clock  (clock),
      .reset  (reset),
      .load   (load),
      .pkt    (pkt),
      .free   (ser_free),
      .strobe (rsp_strobe),
      .data   (rsp_packet_byte),
      .last   (rsp_last_byte)
   );

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> s1_valid_ff)
      else $error("Accepted transaction did not enter the lane pipeline.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !ser_free) |=> (s2_valid_ff && $stable(s2_cmd_ff)))
      else $error("Waiting command changed while the serializer was busy.");

   a_last_with_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last_byte |-> rsp_strobe)
      else $error("Last-byte flag raised outside a transaction.");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Servo bus packet builder testbench
// Drives servo-bus commands through the start/busy handshake and checks every
// packet byte and its last-byte flag against packets built here from the
// command fields. A short directed set covers the clamping edges, the forced
// minimum speed, the direction bit and the unused action codes. Random
// commands then run under three sender idle rates.
// ----------------------------------------------------------------------------
module testbench
   import sbpb_pkg::*;
();

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 24;
   localparam int PRINT_CAP = 60;
   localparam logic [10:0] DIR_FLAG = 11'h400;

   typedef struct {
      logic        [2:0]  action;
      logic        [7:0]  id_a;
      logic        [7:0]  id_b;
      logic signed [15:0] angle_a;
      logic signed [15:0] angle_b;
      logic signed [14:0] speed_a;
      logic signed [14:0] speed_b;
      logic signed [14:0] percent;
      logic               wheel_enable;
   } servo_cmd_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } packet_byte_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic        [2:0]  req_action = '0;
   logic        [7:0]  req_id_a = '0;
   logic        [7:0]  req_id_b = '0;
   logic signed [15:0] req_angle_a = '0;
   logic signed [15:0] req_angle_b = '0;
   logic signed [14:0] req_speed_a = '0;
   logic signed [14:0] req_speed_b = '0;
   logic signed [14:0] req_percent = '0;
   logic               req_wheel_enable = 1'b0;
   logic               rsp_strobe;
   logic        [7:0]  rsp_packet_byte;
   logic               rsp_last_byte;

   servo_cmd_type   pending_cmds[$];
   packet_byte_type expected_bytes[$];
   int              idle_pct = 20;
   int              error_count = 0;
   int              byte_count = 0;
   int              cycle_count = 0;

   servo_bus_packet_builder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_id_a         (req_id_a),
      .req_id_b         (req_id_b),
      .req_angle_a      (req_angle_a),
      .req_angle_b      (req_angle_b),
      .req_speed_a      (req_speed_a),
      .req_speed_b      (req_speed_b),
      .req_percent      (req_percent),
      .req_wheel_enable (req_wheel_enable),
      .rsp_strobe       (rsp_strobe),
      .rsp_packet_byte  (rsp_packet_byte),
      .rsp_last_byte    (rsp_last_byte)
   );

   initial begin
      forever begin
         #4 clock = ~clock;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic int clamp(int x, int lo, int hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   function automatic logic [10:0] angle_raw(int a);
      return 11'(clamp(a, 0, int'(ANGLE_FULL)) * int'(RAW_FULL) / int'(ANGLE_FULL));
   endfunction

   function automatic logic [10:0] pct_raw(int p);
      return 11'(clamp(p, 0, int'(PCT_FULL)) * int'(RAW_FULL) / int'(PCT_FULL));
   endfunction

   function automatic logic [10:0] move_raw(int p);
      logic [10:0] r;
      r = pct_raw(p);
      if (r == 0 && p > 0) begin
         r = 11'd1;
      end
      return r;
   endfunction

   function automatic logic [10:0] wheel_raw(int s);
      int v;
      v = clamp(s, -int'(PCT_FULL), int'(PCT_FULL));
      if (v >= 0) begin
         return pct_raw(v);
      end
      return pct_raw(-v) | DIR_FLAG;
   endfunction

   function automatic void push_word(ref logic [7:0] pkt[$], input logic [10:0] v);
      pkt.push_back(v[7:0]);
      pkt.push_back({5'b0, v[10:8]});
   endfunction

   function automatic void build_packet(servo_cmd_type c);
      logic [7:0]  pkt[$];
      logic [7:0]  sum;
      logic [10:0] move_v;
      logic [10:0] torque_v;
      packet_byte_type entry;
      pkt = {HDR_BYTE, HDR_BYTE};
      move_v = move_raw(c.percent);
      torque_v = pct_raw(c.percent);
      case (action_type'(c.action))
         ACT_SERVO_WRITE: begin
            pkt.push_back(c.id_a);
            pkt.push_back(LEN_SERVO);
            pkt.push_back(INS_WRITE);
            pkt.push_back(ADDR_GOAL);
            push_word(pkt, angle_raw(c.angle_a));
            push_word(pkt, move_v);
         end
         ACT_WHEEL_MODE: begin
            pkt.push_back(c.id_a);
            pkt.push_back(LEN_WHEEL);
            pkt.push_back(INS_WRITE);
            pkt.push_back(ADDR_CCW);
            push_word(pkt, c.wheel_enable ? 11'd0 : RAW_FULL);
         end
         ACT_SYNC_WHEELS: begin
            pkt.push_back(BCAST_ID);
            pkt.push_back(LEN_SWHEEL);
            pkt.push_back(INS_SYNC);
            pkt.push_back(ADDR_SPEED);
            pkt.push_back(SYNC_LEN2);
            pkt.push_back(c.id_a);
            push_word(pkt, wheel_raw(c.speed_a));
            pkt.push_back(c.id_b);
            push_word(pkt, wheel_raw(c.speed_b));
         end
         ACT_SYNC_SERVOS: begin
            pkt.push_back(BCAST_ID);
            pkt.push_back(LEN_SYNC4);
            pkt.push_back(INS_SYNC);
            pkt.push_back(ADDR_GOAL);
            pkt.push_back(SYNC_LEN4);
            pkt.push_back(c.id_a);
            push_word(pkt, angle_raw(c.angle_a));
            push_word(pkt, move_v);
            pkt.push_back(c.id_b);
            push_word(pkt, angle_raw(c.angle_b));
            push_word(pkt, move_v);
         end
         ACT_SYNC_LIMITED: begin
            pkt.push_back(BCAST_ID);
            pkt.push_back(LEN_SYNC4);
            pkt.push_back(INS_SYNC);
            pkt.push_back(ADDR_SPEED);
            pkt.push_back(SYNC_LEN4);
            pkt.push_back(c.id_a);
            push_word(pkt, wheel_raw(c.speed_a));
            push_word(pkt, torque_v);
            pkt.push_back(c.id_b);
            push_word(pkt, wheel_raw(c.speed_b));
            push_word(pkt, torque_v);
         end
         default: begin
            return;
         end
      endcase
      sum = 8'd0;
      for (int i = 2; i < pkt.size(); i++) begin
         sum += pkt[i];
      end
      pkt.push_back(~sum);
      foreach (pkt[i]) begin
         entry.data = pkt[i];
         entry.last = (i == pkt.size() - 1);
         expected_bytes.push_back(entry);
      end
   endfunction

   function automatic servo_cmd_type make_cmd(logic [2:0] action, logic [7:0] id_a,
         logic [7:0] id_b, int angle_a, int angle_b, int speed_a, int speed_b,
         int percent, logic wheel_enable);
      servo_cmd_type c;
      c.action = action;
      c.id_a = id_a;
      c.id_b = id_b;
      c.angle_a = 16'(angle_a);
      c.angle_b = 16'(angle_b);
      c.speed_a = 15'(speed_a);
      c.speed_b = 15'(speed_b);
      c.percent = 15'(percent);
      c.wheel_enable = wheel_enable;
      return c;
   endfunction

   function automatic logic signed [15:0] rand_angle();
      int edges[8] = '{-32768, -1, 0, 1, 29999, 30000, 30001, 32767};
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return 16'(edges[$urandom_range(7)]);
         default: return 16'($urandom_range(30000));
      endcase
   endfunction

   function automatic logic signed [14:0] rand_pct();
      int edges[10] = '{-16384, -10001, -10000, -1, 0, 1, 9, 10000, 10001, 16383};
      case ($urandom_range(3))
         0: return 15'($urandom);
         1: return 15'(edges[$urandom_range(9)]);
         default: return 15'(int'($urandom_range(20000)) - 10000);
      endcase
   endfunction

   function automatic servo_cmd_type rand_cmd();
      servo_cmd_type c;
      if ($urandom_range(99) < 8) begin
         c.action = 3'(ACT_SYNC_LIMITED + 1 + $urandom_range(2));
      end else begin
         c.action = 3'($urandom_range(ACT_SYNC_LIMITED));
      end
      c.id_a = 8'($urandom);
      c.id_b = 8'($urandom);
      c.angle_a = rand_angle();
      c.angle_b = rand_angle();
      c.speed_a = rand_pct();
      c.speed_b = rand_pct();
      c.percent = rand_pct();
      c.wheel_enable = 1'($urandom);
      return c;
   endfunction

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      error_count++;
      if (error_count <= PRINT_CAP) begin
         $display("byte %0d: %s mismatch, got %h expected %h", byte_count, what, got, want);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            build_packet(pending_cmds.pop_front());
         end
         if (!(start && busy)) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
               start <= 1'b1;
               req_action <= pending_cmds[0].action;
               req_id_a <= pending_cmds[0].id_a;
               req_id_b <= pending_cmds[0].id_b;
               req_angle_a <= pending_cmds[0].angle_a;
               req_angle_b <= pending_cmds[0].angle_b;
               req_speed_a <= pending_cmds[0].speed_a;
               req_speed_b <= pending_cmds[0].speed_b;
               req_percent <= pending_cmds[0].percent;
               req_wheel_enable <= pending_cmds[0].wheel_enable;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      packet_byte_type exp_byte;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_packet_byte, 8'h00);
         end else begin
            exp_byte = expected_bytes.pop_front();
            if (rsp_packet_byte !== exp_byte.data) begin
               report_mismatch("packet_byte", rsp_packet_byte, exp_byte.data);
            end
            if (rsp_last_byte !== exp_byte.last) begin
               report_mismatch("last_byte", {7'b0, rsp_last_byte}, {7'b0, exp_byte.last});
            end
         end
         byte_count++;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int phase_pct[3] = '{20, 81, 0};
      pending_cmds.push_back(make_cmd(ACT_SERVO_WRITE, 8'd0, 8'd0, 0, 0, 0, 0, 0, 1'b0));
      pending_cmds.push_back(make_cmd(ACT_SERVO_WRITE, 8'd255, 8'd255, 30000, 0, 0, 0,
                                      10000, 1'b1));
      pending_cmds.push_back(make_cmd(ACT_SERVO_WRITE, 8'd17, 8'd0, -32768, 0, 0, 0,
                                      -16384, 1'b0));
      pending_cmds.push_back(make_cmd(ACT_SERVO_WRITE, 8'd18, 8'd0, 32767, 0, 0, 0,
                                      16383, 1'b0));
      pending_cmds.push_back(make_cmd(ACT_SERVO_WRITE, 8'd19, 8'd0, 29, 0, 0, 0, 1, 1'b0));
      pending_cmds.push_back(make_cmd(ACT_SERVO_WRITE, 8'd20, 8'd0, 30001, 0, 0, 0, 9,
                                      1'b0));
      pending_cmds.push_back(make_cmd(ACT_SERVO_WRITE, 8'd21, 8'd0, -1, 0, 0, 0, 10, 1'b0));
      pending_cmds.push_back(make_cmd(ACT_WHEEL_MODE, 8'd1, 8'd0, 0, 0, 0, 0, 0, 1'b1));
      pending_cmds.push_back(make_cmd(ACT_WHEEL_MODE, 8'd254, 8'd0, 0, 0, 0, 0, 0, 1'b0));
      pending_cmds.push_back(make_cmd(ACT_SYNC_WHEELS, 8'd3, 8'd4, 0, 0, 10000, -10000, 0,
                                      1'b0));
      pending_cmds.push_back(make_cmd(ACT_SYNC_WHEELS, 8'd0, 8'd255, 0, 0, -16384, 16383, 0,
                                      1'b0));
      pending_cmds.push_back(make_cmd(ACT_SYNC_WHEELS, 8'd5, 8'd6, 0, 0, 0, -1, 0, 1'b0));
      pending_cmds.push_back(make_cmd(ACT_SYNC_SERVOS, 8'd7, 8'd8, 0, 30000, 0, 0, 5, 1'b0));
      pending_cmds.push_back(make_cmd(ACT_SYNC_SERVOS, 8'd255, 8'd0, -1, 30001, 0, 0, -1,
                                      1'b0));
      pending_cmds.push_back(make_cmd(ACT_SYNC_SERVOS, 8'd9, 8'd10, -32768, 32767, 0, 0, 0,
                                      1'b1));
      pending_cmds.push_back(make_cmd(ACT_SYNC_LIMITED, 8'd11, 8'd12, 0, 0, 5000, -5000,
                                      -16384, 1'b0));
      pending_cmds.push_back(make_cmd(ACT_SYNC_LIMITED, 8'd13, 8'd14, 0, 0, -16384, 16383,
                                      16383, 1'b0));
      pending_cmds.push_back(make_cmd(ACT_SYNC_LIMITED, 8'd15, 8'd16, 0, 0, -9, 9, 1, 1'b0));
      for (int k = 1; k <= 3; k++) begin
         pending_cmds.push_back(make_cmd(3'(ACT_SYNC_LIMITED + k), 8'd1, 8'd2, 100, 100,
                                         100, 100, 100, 1'b1));
      end
      pending_cmds.push_back(make_cmd(ACT_SERVO_WRITE, 8'd22, 8'd0, 15000, 0, 0, 0, 5000,
                                      1'b0));
      foreach (phase_pct[p]) begin
         @(negedge clock);
         idle_pct = phase_pct[p];
         repeat (30) pending_cmds.push_back(rand_cmd());
         while (pending_cmds.size() != 0) @(negedge clock);
      end
      while (expected_bytes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
